// ===== rtl/canonical_kmer_counter_defines.svh =====
// ----------------------------------------------------------------------------
// Canonical k-mer counter assertion macros
// Shared concurrent assertion forms, sampled on the clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_KMER_COUNTER_DEFINES_SVH
`define CANONICAL_KMER_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CKC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ckc_pkg.sv =====
// ----------------------------------------------------------------------------
// Canonical k-mer counter package
// Field widths, codes, controller states and the control structures.
// ----------------------------------------------------------------------------
package ckc_pkg;

  localparam int OP_W           = 2;
  localparam int BASE_W         = 8;
  localparam int KMER_W         = 8;
  localparam int MERGED_W       = 32;
  localparam int KMER_LEN_W     = 3;
  localparam int MAX_K_DEF      = 4;
  localparam int COUNT_BITS_DEF = 32;

  localparam logic [KMER_LEN_W-1:0] KMER_LEN_RST = 3'd4;

  localparam logic [BASE_W-1:0] CHAR_A = 8'h41;
  localparam logic [BASE_W-1:0] CHAR_C = 8'h43;
  localparam logic [BASE_W-1:0] CHAR_G = 8'h47;
  localparam logic [BASE_W-1:0] CHAR_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'h0;
  localparam logic [1:0] CODE_C = 2'h1;
  localparam logic [1:0] CODE_G = 2'h2;
  localparam logic [1:0] CODE_T = 2'h3;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_CHAR  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC_RD,
    ST_INC_WR,
    ST_Q_RD,
    ST_RC_RD,
    ST_SUM
  } state_e;

  typedef enum logic [1:0] {
    RD_INC,
    RD_QUERY,
    RD_RCOMP
  } rd_sel_e;

  typedef struct packed {
    logic    in_ready;
    logic    sweep;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    inc_wr;
    logic    cap_a;
    logic    load_out;
  } ckc_cmd_t;

  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] op;
    logic            char_valid;
    logic            prefix_full;
    logic            sweep_last;
    logic            out_busy;
  } ckc_status_t;

endpackage

// ===== rtl/ckc_ifs.sv =====
// ----------------------------------------------------------------------------
// Canonical k-mer counter channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface ckc_in_if import ckc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BASE_W-1:0] base_char;
  logic [KMER_W-1:0] query_kmer;

  modport source (output valid, op, base_char, query_kmer, input ready);
  modport sink (input valid, op, base_char, query_kmer, output ready);
endinterface

interface ckc_out_if import ckc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MERGED_W-1:0] merged_count;
  logic [KMER_W-1:0]   rc_kmer;
  logic                is_palindrome;
  logic                is_canonical;

  modport source (output valid, merged_count, rc_kmer, is_palindrome, is_canonical,
                  input ready);
  modport sink (input valid, merged_count, rc_kmer, is_palindrome, is_canonical,
                output ready);
endinterface

// ===== rtl/ckc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ckc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ckc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Canonical k-mer counter controller
// Sequences the clearing sweep, histogram updates and merged count reads.
// ----------------------------------------------------------------------------
module ckc_ctrl import ckc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ckc_status_t status_i,
  output ckc_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (status_i.in_valid) begin
          case (op_e'(status_i.op))
            OP_CLEAR: state_d = ST_CLEAR;
            OP_CHAR: begin
              if (status_i.char_valid && status_i.prefix_full) begin
                state_d = ST_INC_RD;
              end
            end
            OP_READ: state_d = ST_Q_RD;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_INC_RD: state_d = ST_INC_WR;
      ST_INC_WR: state_d = ST_IDLE;
      ST_Q_RD:   state_d = ST_RC_RD;
      ST_RC_RD:  state_d = ST_SUM;
      ST_SUM: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_INC;
    case (state_q)
      ST_CLEAR: cmd_o.sweep = 1'b1;
      ST_IDLE:  cmd_o.in_ready = 1'b1;
      ST_INC_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_INC;
      end
      ST_INC_WR: cmd_o.inc_wr = 1'b1;
      ST_Q_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_QUERY;
      end
      ST_RC_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_RCOMP;
        cmd_o.cap_a  = 1'b1;
      end
      ST_SUM: cmd_o.load_out = !status_i.out_busy;
      default: cmd_o.sweep = 1'b0;
    endcase
  end

endmodule

// ===== rtl/ckc_datapath.sv =====
// ----------------------------------------------------------------------------
// Canonical k-mer counter datapath
// Window, prefix count, reverse complement, saturating adders and result register.
// ----------------------------------------------------------------------------
module ckc_datapath import ckc_pkg::*; #(
  parameter int MAX_K      = MAX_K_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [KMER_LEN_W-1:0]   cfg_wdata_i,
  ckc_in_if.sink                  in_i,
  ckc_out_if.source               out_o,
  input  ckc_cmd_t                cmd_i,
  output ckc_status_t             status_o,
  output logic                    ram_we_o,
  output logic [2*MAX_K-1:0]      ram_waddr_o,
  output logic [COUNT_BITS-1:0]   ram_wdata_o,
  output logic                    ram_re_o,
  output logic [2*MAX_K-1:0]      ram_raddr_o,
  input  logic [COUNT_BITS-1:0]   ram_rdata_i
);

  localparam int KW   = 2 * MAX_K;
  localparam int KL_W = $clog2(MAX_K + 1);
  localparam int XW   = (KW > KMER_W) ? KW : KMER_W;
  localparam int MW   = (COUNT_BITS > MERGED_W) ? COUNT_BITS : MERGED_W;

  logic [KMER_LEN_W-1:0] kmer_len_q;
  logic [KW-1:0]         window_q, window_d;
  logic [KL_W-1:0]       prefix_q, prefix_d;
  logic [KW-1:0]         sweep_q;
  logic [KW-1:0]         inc_addr_q;
  logic [KW-1:0]         qry_q, rc_q;
  logic [COUNT_BITS-1:0] cnt_a_q;
  logic                  out_valid_q;
  logic [MERGED_W-1:0]   merged_q;
  logic [KMER_W-1:0]     rc_out_q;
  logic                  pal_q, canon_q;

  logic [KL_W-1:0]       eff_k, k_m1;
  logic [KW-1:0]         kmask, win_next, qry, rc_full, rc;
  logic [XW-1:0]         qry_ext, rc_ext;
  logic [1:0]            code;
  logic                  char_valid, prefix_full, accept;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sum_sat, inc_val;
  logic [MW-1:0]         merged_ext;

  always_comb begin
    if (kmer_len_q == '0) begin
      eff_k = KL_W'(1);
    end else if (int'(kmer_len_q) > MAX_K) begin
      eff_k = KL_W'(MAX_K);
    end else begin
      eff_k = KL_W'(kmer_len_q);
    end
  end

  assign k_m1 = eff_k - KL_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      kmask[2*i+:2] = (i < int'(eff_k)) ? 2'b11 : 2'b00;
    end
  end

  always_comb begin
    code       = CODE_A;
    char_valid = 1'b1;
    case (in_i.base_char)
      CHAR_A:  code = CODE_A;
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: char_valid = 1'b0;
    endcase
  end

  assign win_next    = (window_q << 2) | KW'(code);
  assign prefix_full = prefix_q >= k_m1;
  assign accept      = in_i.valid && cmd_i.in_ready;

  // The full-width reverse complement is shifted down so only the low k bases remain.
  assign qry_ext = XW'(in_i.query_kmer);
  assign qry     = qry_ext[KW-1:0] & kmask;

  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      rc_full[2*(MAX_K-1-i)+:2] = ~qry[2*i+:2];
    end
  end

  assign rc = rc_full >> (2 * (MAX_K - int'(eff_k)));

  always_comb begin
    window_d = window_q;
    prefix_d = prefix_q;
    if (accept) begin
      case (op_e'(in_i.op))
        OP_CLEAR: begin
          window_d = '0;
          prefix_d = '0;
        end
        OP_CHAR: begin
          if (char_valid) begin
            window_d = win_next;
            prefix_d = prefix_full ? k_m1 : prefix_q + KL_W'(1);
          end
        end
        default: window_d = window_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q  <= KMER_LEN_RST;
      window_q    <= '0;
      prefix_q    <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        kmer_len_q <= cfg_wdata_i;
      end
      window_q <= window_d;
      prefix_q <= prefix_d;
      if (cmd_i.sweep) begin
        sweep_q <= sweep_q + KW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sum        = {1'b0, cnt_a_q} + {1'b0, ram_rdata_i};
  assign sum_sat    = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  assign merged_ext = MW'(sum_sat);
  assign rc_ext     = XW'(rc_q);
  assign inc_val    = (ram_rdata_i == '1) ? ram_rdata_i : ram_rdata_i + COUNT_BITS'(1);

  always_ff @(posedge clk_i) begin
    if (accept && char_valid) begin
      inc_addr_q <= win_next & kmask;
    end
    if (accept) begin
      qry_q <= qry;
      rc_q  <= rc;
    end
    if (cmd_i.cap_a) begin
      cnt_a_q <= ram_rdata_i;
    end
    if (cmd_i.load_out) begin
      merged_q <= merged_ext[MERGED_W-1:0];
      rc_out_q <= rc_ext[KMER_W-1:0];
      pal_q    <= qry_q == rc_q;
      canon_q  <= qry_q <= rc_q;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_QUERY: ram_raddr_o = qry_q;
      RD_RCOMP: ram_raddr_o = rc_q;
      default:  ram_raddr_o = inc_addr_q;
    endcase
  end

  assign ram_re_o    = cmd_i.rd_en;
  assign ram_we_o    = cmd_i.sweep || cmd_i.inc_wr;
  assign ram_waddr_o = cmd_i.sweep ? sweep_q : inc_addr_q;
  assign ram_wdata_o = cmd_i.sweep ? '0 : inc_val;

  assign in_i.ready          = cmd_i.in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.merged_count  = merged_q;
  assign out_o.rc_kmer       = rc_out_q;
  assign out_o.is_palindrome = pal_q;
  assign out_o.is_canonical  = canon_q;

  assign status_o.in_valid    = in_i.valid;
  assign status_o.op          = in_i.op;
  assign status_o.char_valid  = char_valid;
  assign status_o.prefix_full = prefix_full;
  assign status_o.sweep_last  = sweep_q == '1;
  assign status_o.out_busy    = out_valid_q && !out_o.ready;

endmodule

// ===== rtl/canonical_kmer_counter.sv =====
// ----------------------------------------------------------------------------
// Canonical k-mer counter
// Counts k-mers of a DNA stream and returns merged canonical counts on request.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Beat
// in_i      in   valid/ready   op, base_char, query_kmer
// out_o     out  valid/ready   merged_count, rc_kmer, is_palindrome, is_canonical
// cfg       in   cfg_we_i      kmer_len on cfg_wdata_i
//
// A skipped character, a prefix base or an unused op is taken straight from idle; a
// counted base reads and then writes the single histogram RAM.
// A query makes two RAM reads and then the saturating add.
// After reset and after a clear beat, a sweep zeroes all 4^MAX_K histogram entries
// with in_i.ready low; configuration writes are still taken.
// A waiting result stalls the next query, and every beat behind it, until taken.
// ----------------------------------------------------------------------------
`include "canonical_kmer_counter_defines.svh"

module canonical_kmer_counter import ckc_pkg::*; #(
  parameter int MAX_K      = MAX_K_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [KMER_LEN_W-1:0] cfg_wdata_i,
  ckc_in_if.sink                in_i,
  ckc_out_if.source             out_o
);

  localparam int KW    = 2 * MAX_K;
  localparam int DEPTH = 1 << KW;

  ckc_cmd_t              cmd;
  ckc_status_t           status;
  logic                  ram_we, ram_re;
  logic [KW-1:0]         ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  ckc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ckc_datapath #(
    .MAX_K      (MAX_K),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .status_o    (status),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ckc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `CKC_ASSERT_NOW(a_no_result_overwrite, clk_i, rst_ni,
                  out_o.valid && !out_o.ready, !cmd.load_out,
                  "result loaded over a waiting beat")
  `CKC_ASSERT_NEXT(a_clear_starts_sweep, clk_i, rst_ni,
                   in_i.valid && in_i.ready && (in_i.op == OP_CLEAR), cmd.sweep,
                   "clear beat did not start the sweep")
  `CKC_ASSERT_NOW(a_no_accept_during_write, clk_i, rst_ni,
                  ram_we, !in_i.ready,
                  "input beat accepted while the histogram is written")

endmodule

// ===== tb/tb_canonical_kmer_counter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Canonical k-mer counter testbench
// Streams clear, character, read and unused beats into the counter under
// random pacing on both channels and several k-mer lengths. It keeps its own
// window and histogram to predict each read result, and checks every result
// beat field by field in order.
// ----------------------------------------------------------------------------
module tb_canonical_kmer_counter;
  import ckc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [BASE_W-1:0] DNA_CHARS [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BASE_W-1:0] base_char;
    logic [KMER_W-1:0] query;
  } seq_beat_t;

  typedef struct packed {
    logic [MERGED_W-1:0] merged;
    logic [KMER_W-1:0]   rc;
    logic                pal;
    logic                canon;
  } lookup_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [KMER_LEN_W-1:0] cfg_wdata_i;

  ckc_in_if  in_if ();
  ckc_out_if out_if ();

  canonical_kmer_counter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  seq_beat_t             feed_beats [$];
  lookup_t               due_lookups [$];
  logic [KMER_LEN_W-1:0] kmer_len_cfg;
  logic [KMER_W-1:0]     window;
  int unsigned           prefix_seen;
  logic [MERGED_W-1:0]   kmer_hist [256];
  int unsigned           mismatch_cnt;
  int unsigned           tx_idle_pct;
  int unsigned           rx_idle_pct;
  logic                  in_taken;
  logic                  rx_hold;
  logic                  hold_go;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predicts the effect of one accepted input beat on the window, the histogram and the read results.
  task automatic count_kmer_beat(input seq_beat_t b);
    int unsigned         k;
    logic [KMER_W-1:0]   mask;
    logic [KMER_W-1:0]   idx;
    logic [KMER_W-1:0]   q;
    logic [KMER_W-1:0]   rc;
    logic [KMER_W-1:0]   walk;
    logic [1:0]          code;
    logic                is_base;
    logic [MERGED_W:0]   sum;
    lookup_t             res;
    k = (kmer_len_cfg == 0) ? 1 : (kmer_len_cfg > MAX_K_DEF) ? MAX_K_DEF : kmer_len_cfg;
    mask = KMER_W'((16'd1 << (2 * k)) - 1);
    case (b.op)
      OP_CLEAR: begin
        window = '0;
        prefix_seen = 0;
        foreach (kmer_hist[i]) kmer_hist[i] = '0;
      end
      OP_CHAR: begin
        is_base = 1'b1;
        code = CODE_A;
        case (b.base_char)
          CHAR_A: code = CODE_A;
          CHAR_C: code = CODE_C;
          CHAR_G: code = CODE_G;
          CHAR_T: code = CODE_T;
          default: is_base = 1'b0;
        endcase
        if (is_base) begin
          window = {window[KMER_W-3:0], code};
          if (prefix_seen >= k - 1) begin
            idx = window & mask;
            if (kmer_hist[idx] != '1) kmer_hist[idx] = kmer_hist[idx] + 1'b1;
            prefix_seen = k - 1;
          end else begin
            prefix_seen++;
          end
        end
      end
      OP_READ: begin
        q = b.query & mask;
        walk = q;
        rc = '0;
        for (int i = 0; i < k; i++) begin
          rc = {rc[KMER_W-3:0], ~walk[1:0]};
          walk = walk >> 2;
        end
        rc = rc & mask;
        res.pal = (q == rc);
        sum = res.pal ? {1'b0, kmer_hist[q]} + kmer_hist[q]
                      : {1'b0, kmer_hist[q]} + kmer_hist[rc];
        res.merged = sum[MERGED_W] ? '1 : sum[MERGED_W-1:0];
        res.rc = rc;
        res.canon = (q <= rc);
        due_lookups.push_back(res);
      end
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    seq_beat_t nxt;
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (feed_beats.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = feed_beats.pop_front();
          in_if.valid      <= 1'b1;
          in_if.op         <= nxt.op;
          in_if.base_char  <= nxt.base_char;
          in_if.query_kmer <= nxt.query;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    lookup_t want;
    lookup_t got;
    if (rst_ni === 1'b1) begin
      in_taken <= in_if.valid && in_if.ready;
      if (cfg_we_i) kmer_len_cfg = cfg_wdata_i;
      if (in_if.valid && in_if.ready)
        count_kmer_beat({in_if.op, in_if.base_char, in_if.query_kmer});
      if (out_if.valid && out_if.ready) begin
        got = {out_if.merged_count, out_if.rc_kmer, out_if.is_palindrome,
               out_if.is_canonical};
        if (due_lookups.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result beat with nothing pending: count %0d rc %02h pal %b can %b",
                     $realtime, got.merged, got.rc, got.pal, got.canon);
        end else begin
          want = due_lookups.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: result mismatch: count %0d/%0d rc %02h/%02h pal %b/%b can %b/%b",
                       $realtime, got.merged, want.merged, got.rc, want.rc,
                       got.pal, want.pal, got.canon, want.canon);
          end
        end
      end
    end else begin
      in_taken <= 1'b0;
    end
  end

  // The receiver holds off long enough for a waiting result to block the input.
  initial begin
    wait (hold_go === 1'b1);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("canonical_kmer_counter verification failed");
    $finish;
  end

  task automatic push_beat(input logic [OP_W-1:0] op, input logic [BASE_W-1:0] ch,
                           input logic [KMER_W-1:0] q);
    feed_beats.push_back({op, ch, q});
  endtask

  task automatic random_beats(input int n);
    int unsigned       r;
    logic [BASE_W-1:0] ch;
    logic [KMER_W-1:0] q;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      ch = $urandom_range(0, 255);
      q = $urandom_range(0, 255);
      if (r == 0) begin
        push_beat(OP_CLEAR, ch, q);
      end else if (r < 60) begin
        if ($urandom_range(0, 99) < 85) ch = DNA_CHARS[$urandom_range(0, 3)];
        push_beat(OP_CHAR, ch, q);
      end else if (r < 95) begin
        push_beat(OP_READ, ch, q);
      end else begin
        push_beat(OP_UNUSED, ch, q);
      end
    end
  endtask

  task automatic set_kmer_len(input logic [KMER_LEN_W-1:0] len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Waits until every beat is taken and every result is back, then lets a
  // histogram clear or a pending count finish before the next phase.
  task automatic settle();
    while (feed_beats.size() != 0 || in_if.valid) @(posedge clk_i);
    while (due_lookups.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_CLEAR;
    in_if.base_char  = '0;
    in_if.query_kmer = '0;
    out_if.ready     = 1'b0;
    in_taken         = 1'b0;
    rx_hold          = 1'b0;
    hold_go          = 1'b0;
    mismatch_cnt     = 0;
    tx_idle_pct      = 26;
    rx_idle_pct      = 79;
    kmer_len_cfg     = KMER_LEN_RST;
    window           = '0;
    prefix_seen      = 0;
    foreach (kmer_hist[i]) kmer_hist[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_beat(OP_READ, 8'h00, 8'h00);
    push_beat(OP_CHAR, CHAR_A, 8'hFF);
    push_beat(OP_CHAR, CHAR_C, 8'h00);
    push_beat(OP_CHAR, CHAR_G, 8'hAA);
    push_beat(OP_CHAR, CHAR_T, 8'h55);
    push_beat(OP_CHAR, 8'h4E, 8'h00);
    push_beat(OP_CHAR, 8'h00, 8'hFF);
    push_beat(OP_CHAR, 8'hFF, 8'h00);
    push_beat(OP_CHAR, 8'h61, 8'h00);
    push_beat(OP_CHAR, CHAR_A, 8'h00);
    push_beat(OP_READ, 8'hFF, 8'h1B);
    push_beat(OP_READ, 8'h00, 8'hFF);
    push_beat(OP_READ, 8'h00, 8'h6C);
    push_beat(OP_READ, 8'h00, 8'h00);
    push_beat(OP_UNUSED, 8'hA5, 8'h5A);
    push_beat(OP_CLEAR, 8'hFF, 8'hFF);
    push_beat(OP_READ, 8'h00, 8'h1B);
    push_beat(OP_CHAR, CHAR_T, 8'h00);
    push_beat(OP_CHAR, CHAR_T, 8'h00);
    push_beat(OP_CHAR, CHAR_T, 8'h00);
    push_beat(OP_CHAR, CHAR_T, 8'h00);
    push_beat(OP_CHAR, CHAR_T, 8'h00);
    push_beat(OP_READ, 8'h00, 8'h00);
    push_beat(OP_READ, 8'h00, 8'hFF);
    settle();

    set_kmer_len(3'd4);
    random_beats(230);
    settle();
    set_kmer_len(3'd1);
    random_beats(230);
    settle();

    tx_idle_pct = 79;
    rx_idle_pct = 26;
    set_kmer_len(3'd0);
    random_beats(230);
    settle();
    set_kmer_len(3'd7);
    random_beats(230);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_kmer_len(3'd2);
    random_beats(230);
    hold_go = 1'b1;
    settle();
    set_kmer_len(3'd3);
    random_beats(230);
    settle();

    if (mismatch_cnt == 0 && due_lookups.size() == 0) begin
      $display("canonical_kmer_counter verification clean");
    end else begin
      $display("canonical_kmer_counter verification failed");
    end
    $finish;
  end

endmodule

// ===== canonical_kmer_counter.f =====
+incdir+rtl
rtl/ckc_pkg.sv
rtl/ckc_ifs.sv
rtl/ckc_ram.sv
rtl/ckc_ctrl.sv
rtl/ckc_datapath.sv
rtl/canonical_kmer_counter.sv
tb/tb_canonical_kmer_counter.sv
